FILE: hw/rtl/m3i_pkg.sv
`default_nettype none

package m3i_pkg;

   localparam int unsigned NUM_ELEMS = 9;

   typedef logic [3:0] elem_idx_type;

   typedef struct packed {
      logic cof_neg;
      logic det_neg;
   } sign_type;

   // adjugate entry i = e[a]*e[b] - e[c]*e[d]
   localparam elem_idx_type COF_IDX [NUM_ELEMS][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

`default_nettype wire

FILE: hw/rtl/m3i_div_lane.sv
`default_nettype none

module m3i_div_lane #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                      clock,
   input  wire m3i_pkg::sign_type         sign,
   input  wire logic [2*ELEM_WIDTH-1:0]   cof_mag,
   input  wire logic [3*ELEM_WIDTH+2:0]   det_mag,
   output logic      [ELEM_WIDTH-1:0]     quot,
   output logic                           sat
);
   import m3i_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int DW = 3*W+3;
   localparam int NW = 2*W+2*FRAC_BITS;
   localparam int HW = NW-W-1;
   localparam int CW = ((HW > DW) ? HW : DW) + 1;
   localparam int RW = DW+1;
   localparam int QW = W+1;
   localparam int NS = W+1;

   logic [DW-1:0] rem_ff [NS+1];
   logic [DW-1:0] d_ff   [NS+1];
   logic [QW-1:0] nl_ff  [NS+1];
   logic [QW-1:0] q_ff   [NS+1];
   logic          ovf_ff [NS+1];
   logic          neg_ff [NS+1];

   logic [NW-1:0] num;
   logic [HW-1:0] nhi;
   logic          ovf_in;

   // overflow when the quotient reaches 2^(W+1); otherwise only W+1 bits remain
   always_comb begin
      num    = NW'(cof_mag) << (2*FRAC_BITS);
      nhi    = num[NW-1:W+1];
      ovf_in = CW'(nhi) >= CW'(det_mag);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= ovf_in ? '0 : DW'(nhi);
      d_ff[0]   <= det_mag;
      nl_ff[0]  <= num[W:0];
      q_ff[0]   <= '0;
      ovf_ff[0] <= ovf_in;
      neg_ff[0] <= sign.cof_neg ^ sign.det_neg;
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [RW-1:0] trial;
      logic          ge;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k-1], nl_ff[k-1][W]};
         ge     = trial >= RW'(d_ff[k-1]);
         rem_in = ge ? DW'(trial - RW'(d_ff[k-1])) : DW'(trial);
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         d_ff[k]   <= d_ff[k-1];
         nl_ff[k]  <= {nl_ff[k-1][W-1:0], 1'b0};
         q_ff[k]   <= {q_ff[k-1][W-1:0], ge};
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   localparam logic [QW-1:0] LIM = QW'(1) << (W-1);

   always_comb begin
      if (neg_ff[NS]) begin
         sat  = ovf_ff[NS] || (q_ff[NS] > LIM);
         quot = sat ? {1'b1, {(W-1){1'b0}}} : W'(-q_ff[NS][W-1:0]);
      end else begin
         sat  = ovf_ff[NS] || (q_ff[NS] >= LIM);
         quot = sat ? {1'b0, {(W-1){1'b1}}} : q_ff[NS][W-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/matrix3_inverse.sv
`default_nettype none

// 3x3 matrix inverse, signed fixed point (ELEM_WIDTH bits, FRAC_BITS fractional)
//
// input: pulse start with the nine row-major elements on req_in_*; a beat is
// taken on every edge with start high and busy low. busy stays low, so a new
// matrix may enter on every cycle.
// output: rsp_valid is high for one cycle with the nine inverse elements,
// rsp_singular (zero determinant, input echoed) and rsp_saturated (some
// element clamped). the receiver cannot stall; every beat must be taken.
// throughput: one matrix per cycle. the restoring divider in each of the
// nine lanes resolves one quotient bit per pipeline stage (ELEM_WIDTH+1
// stages), behind five stages of cofactor and determinant products.
// reset clears the pipeline valid bits; beats in flight are dropped.
module matrix3_inverse #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r0c0,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r0c1,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r0c2,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r1c0,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r1c1,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r1c2,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r2c0,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r2c1,
   input  wire logic signed [ELEM_WIDTH-1:0] req_in_r2c2,
   output logic                              rsp_valid,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r0c0,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r0c1,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r0c2,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r1c0,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r1c1,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r1c2,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r2c0,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r2c1,
   output logic signed      [ELEM_WIDTH-1:0] rsp_out_r2c2,
   output logic                              rsp_singular,
   output logic                              rsp_saturated
);
   import m3i_pkg::*;

   localparam int W   = ELEM_WIDTH;
   localparam int PW  = 2*W;
   localparam int CW2 = 2*W+1;
   localparam int DW  = 3*W+3;
   localparam int LAT = W+2;
   localparam int PD  = LAT+5;

   logic signed [W-1:0]   req_elem [NUM_ELEMS];
   logic signed [W-1:0]   ep_ff    [PD][NUM_ELEMS];
   logic                  vp_ff    [PD];
   logic                  zp_ff    [LAT];
   logic signed [PW-1:0]  prod_ff  [NUM_ELEMS][2];
   logic signed [CW2-1:0] cof_ff   [NUM_ELEMS];
   logic signed [CW2-1:0] cofd_ff  [NUM_ELEMS];
   logic signed [CW2-1:0] cofe_ff  [NUM_ELEMS];
   logic signed [CW2-1:0] pl_ff    [3];
   logic signed [CW2-1:0] ph_ff    [3];
   logic signed [DW-1:0]  det_ff;
   logic signed [DW-1:0]  det_in;
   logic        [DW-1:0]  det_mag;
   logic        [W-1:0]   lane_quot [NUM_ELEMS];
   logic                  lane_sat  [NUM_ELEMS];
   logic                  sat_any;
   logic                  accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      req_elem[0] = req_in_r0c0;
      req_elem[1] = req_in_r0c1;
      req_elem[2] = req_in_r0c2;
      req_elem[3] = req_in_r1c0;
      req_elem[4] = req_in_r1c1;
      req_elem[5] = req_in_r1c2;
      req_elem[6] = req_in_r2c0;
      req_elem[7] = req_in_r2c1;
      req_elem[8] = req_in_r2c2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PD; k++) vp_ff[k] <= 1'b0;
      end else begin
         vp_ff[0] <= accept;
         for (int k = 1; k < PD; k++) vp_ff[k] <= vp_ff[k-1];
      end
   end

   // element delay line, kept for the singular pass-through
   always_ff @(posedge clock) begin
      ep_ff[0] <= req_elem;
      for (int k = 1; k < PD; k++) ep_ff[k] <= ep_ff[k-1];
   end

   // cofactor products and differences
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
         prod_ff[i][0] <= PW'(ep_ff[0][COF_IDX[i][0]]) * PW'(ep_ff[0][COF_IDX[i][1]]);
         prod_ff[i][1] <= PW'(ep_ff[0][COF_IDX[i][2]]) * PW'(ep_ff[0][COF_IDX[i][3]]);
         cof_ff[i]     <= CW2'(prod_ff[i][0]) - CW2'(prod_ff[i][1]);
      end
      cofd_ff <= cof_ff;
      cofe_ff <= cofd_ff;
   end

   // determinant along row 0, each cofactor split in low and high halves
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         pl_ff[j] <= CW2'(ep_ff[2][j])
                     * CW2'($signed({1'b0, cof_ff[3*j][W-1:0]}));
         ph_ff[j] <= CW2'(ep_ff[2][j]) * CW2'($signed(cof_ff[3*j][CW2-1:W]));
      end
      det_ff <= det_in;
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (DW'(ph_ff[j]) <<< W) + DW'(pl_ff[j]);
      end
      det_mag = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   end

   always_ff @(posedge clock) begin
      zp_ff[0] <= (det_ff == '0);
      for (int k = 1; k < LAT; k++) zp_ff[k] <= zp_ff[k-1];
   end

   for (genvar i = 0; i < NUM_ELEMS; i++) begin : g_lane
      sign_type           sign;
      logic     [PW-1:0]  cof_mag;

      always_comb begin
         sign.cof_neg = cofe_ff[i][CW2-1];
         sign.det_neg = det_ff[DW-1];
         cof_mag      = cofe_ff[i][CW2-1] ? PW'(-cofe_ff[i]) : PW'(cofe_ff[i]);
      end

      m3i_div_lane #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .sign    (sign),
         .cof_mag (cof_mag),
         .det_mag (det_mag),
         .quot    (lane_quot[i]),
         .sat     (lane_sat[i])
      );
   end

   always_comb begin
      sat_any = 1'b0;
      for (int i = 0; i < NUM_ELEMS; i++) sat_any = sat_any | lane_sat[i];
   end

   // merge stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= vp_ff[PD-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_singular  <= zp_ff[LAT-1];
      rsp_saturated <= !zp_ff[LAT-1] && sat_any;
      rsp_out_r0c0  <= zp_ff[LAT-1] ? ep_ff[PD-1][0] : $signed(lane_quot[0]);
      rsp_out_r0c1  <= zp_ff[LAT-1] ? ep_ff[PD-1][1] : $signed(lane_quot[1]);
      rsp_out_r0c2  <= zp_ff[LAT-1] ? ep_ff[PD-1][2] : $signed(lane_quot[2]);
      rsp_out_r1c0  <= zp_ff[LAT-1] ? ep_ff[PD-1][3] : $signed(lane_quot[3]);
      rsp_out_r1c1  <= zp_ff[LAT-1] ? ep_ff[PD-1][4] : $signed(lane_quot[4]);
      rsp_out_r1c2  <= zp_ff[LAT-1] ? ep_ff[PD-1][5] : $signed(lane_quot[5]);
      rsp_out_r2c0  <= zp_ff[LAT-1] ? ep_ff[PD-1][6] : $signed(lane_quot[6]);
      rsp_out_r2c1  <= zp_ff[LAT-1] ? ep_ff[PD-1][7] : $signed(lane_quot[7]);
      rsp_out_r2c2  <= zp_ff[LAT-1] ? ep_ff[PD-1][8] : $signed(lane_quot[8]);
   end

`ifndef ASSERT_OFF
   a_beat_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(PD+1) rsp_valid)
      else $error("accepted beat did not appear at the output");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !vp_ff[PD-1] |=> !rsp_valid)
      else $error("result strobe without a beat in flight");

   a_singular_unsat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated)
      else $error("singular result flagged as saturated");
`endif

endmodule

`default_nettype wire
